// ----- hw/rtl/sph2cart_pkg.sv -----
// ============================================================================
// sph2cart_pkg
// Shared constants, types and the arctangent table for the spherical to
// Cartesian converter.
// ============================================================================
`default_nettype none

package sph2cart_pkg;

    localparam int AngleW = 16;
    localparam int CordW  = 34;
    localparam int ZW     = 34;
    localparam int TrigW  = 18;
    localparam int CoordW = 24;
    localparam int TblLen = 24;

    localparam logic signed [CordW-1:0] GainQ30 = 34'sd652032874;
    localparam logic signed [ZW-1:0]    HalfTurn = 34'sd2147483648;

    // Per-angle CORDIC working set
    typedef struct packed {
        logic signed [CordW-1:0] x;
        logic signed [CordW-1:0] y;
        logic signed [ZW-1:0]    z;
        logic                    flip;
    } cordic_t;

    // Arctangent of 2^-i, one turn = 2^32
    function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        begin
            case (idx)
                5'd0:  v = 34'sd536870912;
                5'd1:  v = 34'sd316933406;
                5'd2:  v = 34'sd167458907;
                5'd3:  v = 34'sd85004756;
                5'd4:  v = 34'sd42667331;
                5'd5:  v = 34'sd21354465;
                5'd6:  v = 34'sd10679838;
                5'd7:  v = 34'sd5340245;
                5'd8:  v = 34'sd2670163;
                5'd9:  v = 34'sd1335087;
                5'd10: v = 34'sd667544;
                5'd11: v = 34'sd333772;
                5'd12: v = 34'sd166886;
                5'd13: v = 34'sd83443;
                5'd14: v = 34'sd41721;
                5'd15: v = 34'sd20860;
                5'd16: v = 34'sd10430;
                5'd17: v = 34'sd5215;
                5'd18: v = 34'sd2607;
                5'd19: v = 34'sd1303;
                5'd20: v = 34'sd651;
                5'd21: v = 34'sd325;
                5'd22: v = 34'sd162;
                5'd23: v = 34'sd81;
                default: v = '0;
            endcase
            atan_lut = v;
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sph2cart_cordic_stage.sv -----
// ============================================================================
// sph2cart_cordic_stage
// One registered rotation-mode CORDIC micro-rotation.
// ============================================================================
`default_nettype none

module sph2cart_cordic_stage
    import sph2cart_pkg::*;
#(
    parameter int Idx = 0
)
(
    input  wire logic    clk,
    input  wire cordic_t din,
    output cordic_t      dout
);

    cordic_t rot_next;
    cordic_t rot_reg;

    // Rotate towards zero residual angle
    always_comb
    begin
        rot_next = din;
        if (Idx < TblLen) begin
            if (din.z >= 0) begin
                rot_next.x = din.x - (din.y >>> Idx);
                rot_next.y = din.y + (din.x >>> Idx);
                rot_next.z = din.z - atan_lut(5'(Idx));
            end
            else begin
                rot_next.x = din.x + (din.y >>> Idx);
                rot_next.y = din.y - (din.x >>> Idx);
                rot_next.z = din.z + atan_lut(5'(Idx));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rot_reg <= rot_next;
    end

    assign dout = rot_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/sph2cart_cordic.sv -----
// ============================================================================
// sph2cart_cordic
// Pipelined sine/cosine of a binary angle, results rounded to Q.16.
// ============================================================================
`default_nettype none

module sph2cart_cordic
    import sph2cart_pkg::*;
#(
    parameter int STAGES = 16
)
(
    input  wire logic                     clk,
    input  wire logic signed [AngleW-1:0] angle,
    output logic signed [TrigW-1:0]       cos_q16,
    output logic signed [TrigW-1:0]       sin_q16
);

    cordic_t chain [0:STAGES];
    cordic_t init_next;
    cordic_t init_reg;
    logic signed [CordW-1:0] xf;
    logic signed [CordW-1:0] yf;
    logic signed [TrigW-1:0] cos_reg;
    logic signed [TrigW-1:0] sin_reg;

    // Fold the angle into the right half-plane
    always_comb
    begin
        init_next.x    = GainQ30;
        init_next.y    = '0;
        init_next.z    = {{(ZW-AngleW-16){angle[AngleW-1]}}, angle, 16'd0};
        init_next.flip = 1'b0;
        if (angle > 16'sd16384) begin
            init_next.z    = init_next.z - HalfTurn;
            init_next.flip = 1'b1;
        end
        else if (angle < -16'sd16384) begin
            init_next.z    = init_next.z + HalfTurn;
            init_next.flip = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        init_reg <= init_next;
    end

    assign chain[0] = init_reg;

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        sph2cart_cordic_stage #(.Idx(i)) u_stage (
            .clk  (clk),
            .din  (chain[i]),
            .dout (chain[i+1])
        );
    end

    // Undo the fold and round Q.30 to Q.16
    always_comb
    begin
        xf = chain[STAGES].flip ? -chain[STAGES].x : chain[STAGES].x;
        yf = chain[STAGES].flip ? -chain[STAGES].y : chain[STAGES].y;
    end

    always_ff @(posedge clk)
    begin
        cos_reg <= TrigW'((xf + 34'sd8192) >>> 14);
        sin_reg <= TrigW'((yf + 34'sd8192) >>> 14);
    end

    assign cos_q16 = cos_reg;
    assign sin_q16 = sin_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/sph2cart_scale.sv -----
// ============================================================================
// sph2cart_scale
// Radius times trig products, rounding, center offset and saturation.
// ============================================================================
`default_nettype none

module sph2cart_scale
    import sph2cart_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic [15:0]              radius,
    input  wire logic signed [TrigW-1:0]  ci,
    input  wire logic signed [TrigW-1:0]  si,
    input  wire logic signed [TrigW-1:0]  ca,
    input  wire logic signed [TrigW-1:0]  sa,
    input  wire logic signed [CoordW-1:0] cx,
    input  wire logic signed [CoordW-1:0] cy,
    input  wire logic signed [CoordW-1:0] cz,
    output logic signed [CoordW-1:0]      px,
    output logic signed [CoordW-1:0]      py,
    output logic signed [CoordW-1:0]      pz,
    output logic                          clip
);

    localparam int PW = 52;

    logic signed [35:0] rs_reg;
    logic signed [35:0] rc_reg;
    logic signed [TrigW-1:0] ca_reg, sa_reg;
    logic signed [CoordW-1:0] cx1_reg, cy1_reg, cz1_reg;
    logic signed [CoordW-1:0] cx2_reg, cy2_reg, cz2_reg;
    logic signed [PW-1:0] ox_reg, oy_reg, oz_reg;
    logic signed [PW-1:0] sx, sy, sz;
    logic signed [CoordW-1:0] px_reg, py_reg, pz_reg;
    logic clip_reg;
    logic cl_x, cl_y, cl_z;
    logic signed [CoordW-1:0] qx, qy, qz;

    // First product: radius by inclination terms
    always_ff @(posedge clk)
    begin
        rs_reg  <= 36'($signed({1'b0, radius}) * si);
        rc_reg  <= 36'($signed({1'b0, radius}) * ci);
        ca_reg  <= ca;
        sa_reg  <= sa;
        cx1_reg <= cx;
        cy1_reg <= cy;
        cz1_reg <= cz;
    end

    // Second product by azimuth terms, z scaled by 2^16
    always_ff @(posedge clk)
    begin
        ox_reg  <= PW'(rs_reg * ca_reg);
        oy_reg  <= PW'(rs_reg * sa_reg);
        oz_reg  <= PW'({rc_reg, 16'd0});
        cx2_reg <= cx1_reg;
        cy2_reg <= cy1_reg;
        cz2_reg <= cz1_reg;
    end

    function automatic logic signed [CoordW-1:0] sat(input logic signed [PW-1:0] v,
                                                   output logic c);
        begin
            c = 1'b0;
            if (v > 52'sd8388607) begin
                c = 1'b1;
                sat = 24'sh7FFFFF;
            end
            else if (v < -52'sd8388608) begin
                c = 1'b1;
                sat = 24'sh800000;
            end
            else begin
                sat = v[CoordW-1:0];
            end
        end
    endfunction

    // Round the Q.32 products to whole radius units, add center, clamp
    always_comb
    begin
        sx = ((ox_reg + 52'sd2147483648) >>> 32) + PW'(cx2_reg);
        sy = ((oy_reg + 52'sd2147483648) >>> 32) + PW'(cy2_reg);
        sz = ((oz_reg + 52'sd2147483648) >>> 32) + PW'(cz2_reg);
        qx = sat(sx, cl_x);
        qy = sat(sy, cl_y);
        qz = sat(sz, cl_z);
    end

    always_ff @(posedge clk)
    begin
        px_reg   <= qx;
        py_reg   <= qy;
        pz_reg   <= qz;
        clip_reg <= cl_x | cl_y | cl_z;
    end

    assign px   = px_reg;
    assign py   = py_reg;
    assign pz   = pz_reg;
    assign clip = clip_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/spherical_to_cartesian_offset.sv -----
// ============================================================================
// spherical_to_cartesian_offset
// Spherical point plus center to saturated Cartesian point, fully pipelined.
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------------
//   input    | start, busy        | radius, inclination, azimuth, center_*
//   result   | done (one cycle)   | point_x, point_y, point_z, clipped
//
// One item enters per cycle; busy is always low. Each item passes
// through the CORDIC chain with its fold and rounding registers, the
// two multiplier stages and the output register. Reset clears only the
// valid bits. The receiver cannot stall, so the pipeline never holds.
// ============================================================================
`default_nettype none

module spherical_to_cartesian_offset
    import sph2cart_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [15:0]        radius,
    input  wire logic signed [15:0] inclination,
    input  wire logic signed [15:0] azimuth,
    input  wire logic signed [23:0] center_x,
    input  wire logic signed [23:0] center_y,
    input  wire logic signed [23:0] center_z,
    output logic                    done,
    output logic signed [23:0]      point_x,
    output logic signed [23:0]      point_y,
    output logic signed [23:0]      point_z,
    output logic                    clipped
);

    localparam int TrigLat = CORDIC_STAGES + 2;
    localparam int Lat     = TrigLat + 3;

    logic [Lat-1:0] vld_reg;
    logic [15:0]              r_reg  [0:TrigLat-1];
    logic signed [CoordW-1:0] cx_reg [0:TrigLat-1];
    logic signed [CoordW-1:0] cy_reg [0:TrigLat-1];
    logic signed [CoordW-1:0] cz_reg [0:TrigLat-1];
    logic signed [TrigW-1:0]  ci, si, ca, sa;

    assign busy = 1'b0;

    // Advance valid bits alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            vld_reg <= {vld_reg[Lat-2:0], start};
        end
    end

    // Delay radius and center to meet the trig results
    always_ff @(posedge clk)
    begin
        r_reg[0]  <= radius;
        cx_reg[0] <= center_x;
        cy_reg[0] <= center_y;
        cz_reg[0] <= center_z;
        for (int i = 1; i < TrigLat; i++) begin
            r_reg[i]  <= r_reg[i-1];
            cx_reg[i] <= cx_reg[i-1];
            cy_reg[i] <= cy_reg[i-1];
            cz_reg[i] <= cz_reg[i-1];
        end
    end

    sph2cart_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_inc (
        .clk (clk), .angle (inclination), .cos_q16 (ci), .sin_q16 (si)
    );

    sph2cart_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_az (
        .clk (clk), .angle (azimuth), .cos_q16 (ca), .sin_q16 (sa)
    );

    sph2cart_scale u_scale (
        .clk    (clk),
        .radius (r_reg[TrigLat-1]),
        .ci     (ci),
        .si     (si),
        .ca     (ca),
        .sa     (sa),
        .cx     (cx_reg[TrigLat-1]),
        .cy     (cy_reg[TrigLat-1]),
        .cz     (cz_reg[TrigLat-1]),
        .px     (point_x),
        .py     (point_y),
        .pz     (point_z),
        .clip   (clipped)
    );

    assign done = vld_reg[Lat-1];

    // Every transfer in is matched by a result strobe
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(Lat) done) else $error("result strobe missing");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, Lat)) else $error("unexpected result strobe");

    // A clipped result has at least one coordinate on a rail
    a_clip_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && clipped) |->
            (point_x == 24'sh7FFFFF || point_x == 24'sh800000 ||
             point_y == 24'sh7FFFFF || point_y == 24'sh800000 ||
             point_z == 24'sh7FFFFF || point_z == 24'sh800000))
        else $error("clip flag without a saturated coordinate");

endmodule

`default_nettype wire
